>>> src/chunk_energy_voice_activity_assert.svh
// ---------------------------------------------------------------------------
// Chunk energy voice activity assertion macros
// Shared property shapes for the checker, clocked on clock, gated by reset.
// ---------------------------------------------------------------------------
`ifndef CHUNK_ENERGY_VOICE_ACTIVITY_ASSERT_SVH
`define CHUNK_ENERGY_VOICE_ACTIVITY_ASSERT_SVH

// Same-cycle implication
`define CEVA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ceva assertion failed");

// Next-cycle implication
`define CEVA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ceva assertion failed");

`endif

>>> src/ceva_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk energy voice activity package
// Widths, reset values, register indexes and controller/datapath structs.
// ---------------------------------------------------------------------------
package ceva_pkg;

   localparam int RATE_W      = 18;
   localparam int LEN_W       = 16;
   localparam int THR_W       = 31;
   localparam int POS_W       = 48;
   localparam int SUM_W       = 48;
   localparam int NEED_W      = THR_W + LEN_W;
   localparam int PROD_W      = POS_W + 10;
   localparam int DIV_CNT_W   = 6;
   localparam int SPAN_W      = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);
   localparam logic [RATE_W-1:0] RATE_ZERO_SUBST = RATE_W'(16000);
   localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(320);
   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(68719);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SAMPLE_RATE  = 2'd0,
      REG_CHUNK_LENGTH = 2'd1,
      REG_THRESHOLD    = 2'd2
   } csr_reg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch_in;
      logic square;
      logic accum;
      logic close;
      logic span_init;
      logic div_step;
      logic emit;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic skip;
      logic eos;
      logic close_due;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> src/ceva_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample channel interface
// Valid/ready channel carrying one audio sample and the end-of-stream flag.
// ---------------------------------------------------------------------------
interface ceva_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          end_of_stream;

   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

>>> src/ceva_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one chunk or end-of-stream result.
// ---------------------------------------------------------------------------
interface ceva_rsp_if;
   logic        valid;
   logic        ready;
   logic        chunk_is_speech;
   logic        speech_seen;
   logic [31:0] span_ms;
   logic        final_res;

   modport source (output valid, output chunk_is_speech, output speech_seen,
                   output span_ms, output final_res, input ready);
   modport sink   (input valid, input chunk_is_speech, input speech_seen,
                   input span_ms, input final_res, output ready);
endinterface

>>> src/ceva_csr_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register write interface
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface ceva_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [30:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/ceva_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk energy voice activity controller
// Sequences accept, square, accumulate, chunk close, span divide and emit.
// ---------------------------------------------------------------------------
module ceva_ctrl
   import ceva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SQUARE = 7'b0000010,
      S_ACCUM  = 7'b0000100,
      S_CLOSE  = 7'b0001000,
      S_SPAN   = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_in = 1'b1;
               state_in     = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (status.skip) begin
               state_in = status.eos ? S_SPAN : S_IDLE;
            end else begin
               cmd.square = 1'b1;
               state_in   = S_ACCUM;
            end
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.close_due ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = status.eos ? S_SPAN : S_EMIT;
         end
         S_SPAN: begin
            cmd.span_init = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/ceva_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk energy voice activity datapath
// Registers, energy accumulator, speech run tracking, span divider, output.
// ---------------------------------------------------------------------------
module ceva_datapath
   import ceva_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_CHUNKS  = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_eos,
   input  logic                          csr_valid,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_chunk_is_speech,
   output logic                          rsp_speech_seen,
   output logic [SPAN_W-1:0]             rsp_span_ms,
   output logic                          rsp_final_res
);

   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);

   // Configuration registers
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [THR_W-1:0]  thr_ff, thr_in;

   // Stream state
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CHUNK_W-1:0] chunks_ff, chunks_in;
   logic               in_speech_ff, in_speech_in;
   logic               any_speech_ff, any_speech_in;
   logic [POS_W-1:0]   run_start_ff, run_start_in;
   logic [POS_W-1:0]   run_end_ff, run_end_in;

   // Per-transaction payload
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic                   eos_ff, eos_in;
   logic                   skip_ff, skip_in;
   logic                   speech_ff, speech_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [NEED_W-1:0]      need_ff, need_in;

   // Span divider
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_speech_ff, rsp_speech_in;
   logic              rsp_seen_ff, rsp_seen_in;
   logic [SPAN_W-1:0] rsp_span_ff, rsp_span_in;
   logic              rsp_final_ff, rsp_final_in;

   logic [LEN_W-1:0]  len_eff;
   logic [POS_W-1:0]  chunk_end;
   logic [POS_W-1:0]  run_diff;
   logic [PROD_W-1:0] diff_ms;
   logic [RATE_W:0]   rem_shift;
   logic              rem_ge;
   logic              chunk_speech;
   logic [SPAN_W-1:0] span_sat;

   assign len_eff      = (len_ff == '0) ? LEN_W'(1) : len_ff;
   assign chunk_end    = pos_ff + POS_W'(cnt_ff);
   assign chunk_speech = (SUM_W'(need_ff) <= sum_ff);
   assign run_diff     = run_end_ff - run_start_ff;
   // Multiply by 1000 as 1024 - 16 - 8
   assign diff_ms      = {run_diff, 10'b0} - PROD_W'({run_diff, 4'b0})
                         - PROD_W'({run_diff, 3'b0});
   assign rem_shift    = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_ge       = (rem_shift >= {1'b0, divisor_ff});
   assign span_sat     = (quo_ff[PROD_W-1:SPAN_W] != '0) ? '1 : quo_ff[SPAN_W-1:0];

   assign status.skip      = skip_ff;
   assign status.eos       = eos_ff;
   assign status.close_due = (cnt_ff >= len_eff) || eos_ff;
   assign status.div_last  = (div_cnt_ff == DIV_CNT_W'(PROD_W - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chunk_is_speech = rsp_speech_ff;
   assign rsp_speech_seen     = rsp_seen_ff;
   assign rsp_span_ms         = rsp_span_ff;
   assign rsp_final_res       = rsp_final_ff;

   // Decode register writes
   always_comb begin
      rate_in = rate_ff;
      len_in  = len_ff;
      thr_in  = thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SAMPLE_RATE:  rate_in = csr_data[RATE_W-1:0];
            REG_CHUNK_LENGTH: len_in  = csr_data[LEN_W-1:0];
            REG_THRESHOLD:    thr_in  = csr_data[THR_W-1:0];
            default:          ;
         endcase
      end
   end

   // Latch input, square, accumulate, close chunk
   always_comb begin
      mag_in        = mag_ff;
      eos_in        = eos_ff;
      skip_in       = skip_ff;
      speech_in     = speech_ff;
      sq_in         = sq_ff;
      need_in       = need_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      chunks_in     = chunks_ff;
      in_speech_in  = in_speech_ff;
      any_speech_in = any_speech_ff;
      run_start_in  = run_start_ff;
      run_end_in    = run_end_ff;

      if (cmd.latch_in) begin
         mag_in    = req_sample[SAMPLE_BITS-1] ? (~req_sample + SAMPLE_BITS'(1))
                                               : req_sample;
         eos_in    = req_eos;
         skip_in   = (chunks_ff >= CHUNK_W'(MAX_CHUNKS));
         speech_in = 1'b0;
      end

      if (cmd.square) begin
         sq_in  = SQ_W'(mag_ff) * SQ_W'(mag_ff);
         cnt_in = cnt_ff + LEN_W'(1);
      end

      if (cmd.accum) begin
         sum_in  = sum_ff + SUM_W'(sq_ff);
         need_in = NEED_W'(thr_ff) * NEED_W'(cnt_ff);
      end

      if (cmd.close) begin
         speech_in = chunk_speech;
         if (chunk_speech) begin
            if (!in_speech_ff) begin
               run_start_in = pos_ff;
            end
            in_speech_in  = 1'b1;
            run_end_in    = chunk_end;
            any_speech_in = 1'b1;
         end else begin
            in_speech_in = 1'b0;
         end
         pos_in    = chunk_end;
         chunks_in = chunks_ff + CHUNK_W'(1);
         sum_in    = '0;
         cnt_in    = '0;
      end

      // Clear the stream after its final result
      if (cmd.emit && eos_ff) begin
         sum_in        = '0;
         cnt_in        = '0;
         pos_in        = '0;
         chunks_in     = '0;
         in_speech_in  = 1'b0;
         any_speech_in = 1'b0;
         run_start_in  = '0;
         run_end_in    = '0;
      end
   end

   // Bit-serial span divide, one quotient bit per cycle
   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.span_init) begin
         quo_in     = (any_speech_ff && (run_end_ff > run_start_ff)) ? diff_ms : '0;
         rem_in     = '0;
         divisor_in = (rate_ff == '0) ? RATE_ZERO_SUBST : rate_ff;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in     = {quo_ff[PROD_W-2:0], rem_ge};
         rem_in     = rem_ge ? RATE_W'(rem_shift - {1'b0, divisor_ff})
                             : rem_shift[RATE_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Load and drain the output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_speech_in = rsp_speech_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_span_in   = rsp_span_ff;
      rsp_final_in  = rsp_final_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_speech_in = speech_ff;
         rsp_seen_in   = any_speech_ff;
         rsp_span_in   = eos_ff ? span_sat : '0;
         rsp_final_in  = eos_ff;
      end
   end

   // Control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= RATE_RESET;
         len_ff        <= LEN_RESET;
         thr_ff        <= THR_RESET;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         pos_ff        <= '0;
         chunks_ff     <= '0;
         in_speech_ff  <= 1'b0;
         any_speech_ff <= 1'b0;
         run_start_ff  <= '0;
         run_end_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rate_ff       <= rate_in;
         len_ff        <= len_in;
         thr_ff        <= thr_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         pos_ff        <= pos_in;
         chunks_ff     <= chunks_in;
         in_speech_ff  <= in_speech_in;
         any_speech_ff <= any_speech_in;
         run_start_ff  <= run_start_in;
         run_end_ff    <= run_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      eos_ff        <= eos_in;
      skip_ff       <= skip_in;
      speech_ff     <= speech_in;
      sq_ff         <= sq_in;
      need_ff       <= need_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_speech_ff <= rsp_speech_in;
      rsp_seen_ff   <= rsp_seen_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_final_ff  <= rsp_final_in;
   end

endmodule

>>> src/chunk_energy_voice_activity.sv
// A sample is latched on accept, then squared and accumulated; a sample that closes a chunk
// then closes it and emits a result, and the end-of-stream sample adds the span divide.
// Past the chunk limit a sample skips squaring and accumulation. A new sample is accepted
// only once the last is done; the span in ms comes from a 58-step bit-serial divider.
// Reset (synchronous, active high) restores register defaults and clears the stream.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk energy voice activity detector
// Chunked sum-of-squares speech detection with speech span in milliseconds.
// ---------------------------------------------------------------------------
module chunk_energy_voice_activity
   import ceva_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_CHUNKS  = 4096
) (
   input  logic         clock,
   input  logic         reset,
   ceva_req_if.sink     req_bus,
   ceva_rsp_if.source   rsp_bus,
   ceva_csr_if.sink     csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   logic signed [SAMPLE_BITS-1:0] req_sample;

   assign req_sample    = SAMPLE_BITS'(req_bus.sample);
   assign req_bus.ready = req_ready;
   // Registers take a write in any cycle
   assign csr_bus.ready = 1'b1;

   ceva_ctrl u_ceva_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ceva_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_CHUNKS  (MAX_CHUNKS)
   ) u_ceva_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample          (req_sample),
      .req_eos             (req_bus.end_of_stream),
      .csr_valid           (csr_bus.valid),
      .csr_index           (csr_bus.index),
      .csr_data            (csr_bus.data),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_chunk_is_speech (rsp_bus.chunk_is_speech),
      .rsp_speech_seen     (rsp_bus.speech_seen),
      .rsp_span_ms         (rsp_bus.span_ms),
      .rsp_final_res       (rsp_bus.final_res)
   );

endmodule

>>> src/ceva_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk energy voice activity checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "chunk_energy_voice_activity_assert.svh"

module ceva_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        chunk_is_speech,
   input logic        speech_seen,
   input logic [31:0] span_ms,
   input logic        final_res
);

   // Hold a stalled result transaction
   `CEVA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // Report a span only on the result closing the stream
   `CEVA_ASSERT_NOW(a_span_final, rsp_valid && (span_ms != 32'd0), final_res)
   // A speech chunk marks the stream as having speech
   `CEVA_ASSERT_NOW(a_speech_seen, rsp_valid && chunk_is_speech, speech_seen)
   // A nonzero span needs some speech
   `CEVA_ASSERT_NOW(a_span_seen, rsp_valid && (span_ms != 32'd0), speech_seen)

endmodule

bind chunk_energy_voice_activity ceva_checker u_ceva_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .chunk_is_speech (rsp_bus.chunk_is_speech),
   .speech_seen     (rsp_bus.speech_seen),
   .span_ms         (rsp_bus.span_ms),
   .final_res       (rsp_bus.final_res)
);
